FILE: sv/cdcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits column renderer package
// Shared payload types, register indexes, frame geometry and digit fonts.
// ----------------------------------------------------------------------------
package cdcr_pkg;

  localparam int NUM_COLS    = 32;
  localparam int COL_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CFG_IDX_HOURS_24_MODE = 1'b0;
  localparam logic CFG_IDX_FLIP_VIEW     = 1'b1;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [4:0] HALF_DAY   = 5'd12;

  localparam logic [COL_W-1:0] X_HOUR_TENS  = 5'd2;
  localparam logic [COL_W-1:0] X_HOUR_UNITS = 5'd7;
  localparam logic [COL_W-1:0] X_COLON      = 5'd12;
  localparam logic [COL_W-1:0] X_MIN_TENS   = 5'd14;
  localparam logic [COL_W-1:0] X_MIN_UNITS  = 5'd19;
  localparam logic [COL_W-1:0] X_SEC_TENS   = 5'd25;
  localparam logic [COL_W-1:0] X_SEC_UNITS  = 5'd29;
  localparam logic [COL_W-1:0] X_LAST       = 5'd31;

  localparam logic [7:0] COLON_BITS = 8'h14;

  typedef struct packed {
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic       colon_on;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [7:0]       column_bits;
    logic             last_column;
  } out_t;

  typedef struct packed {
    logic       hour_tens_blank;
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
    logic [3:0] second_tens;
    logic [3:0] second_units;
    logic       colon_on;
    logic       flip_view;
  } job_t;

  // Row masks, leftmost glyph column in the most significant bit.
  localparam logic [3:0] FONT_BIG [10][7] = '{
    '{4'd6, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd6},
    '{4'd2, 4'd6, 4'd2, 4'd2, 4'd2, 4'd2, 4'd7},
    '{4'd6, 4'd9, 4'd1, 4'd2, 4'd4, 4'd8, 4'd15},
    '{4'd6, 4'd9, 4'd1, 4'd2, 4'd1, 4'd9, 4'd6},
    '{4'd1, 4'd3, 4'd5, 4'd9, 4'd15, 4'd1, 4'd1},
    '{4'd15, 4'd8, 4'd14, 4'd1, 4'd1, 4'd9, 4'd6},
    '{4'd6, 4'd8, 4'd8, 4'd14, 4'd9, 4'd9, 4'd6},
    '{4'd15, 4'd1, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4},
    '{4'd6, 4'd9, 4'd9, 4'd6, 4'd9, 4'd9, 4'd6},
    '{4'd6, 4'd9, 4'd9, 4'd7, 4'd1, 4'd1, 4'd6}
  };

  localparam logic [2:0] FONT_SMALL [10][5] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
    '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
    '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
  };

endpackage

FILE: sv/clock_digits_column_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits column renderer
// Renders a time of day into a 32 by 8 LED frame sent one column at a time.
// ----------------------------------------------------------------------------
// Each accepted time value produces 32 column transfers, one per clock cycle
// while out_ready stays high; the column counter of the back stage sets that
// figure. The first column passes through the queue, the job register and the
// output register of the column stage. A queue of QUEUE_DEPTH jobs sits
// between the front end and the column stage, so new time values are taken
// while a frame is still streaming out. The mode registers are sampled when a
// time value is accepted.
module clock_digits_column_renderer_core #(
  parameter int QUEUE_DEPTH = cdcr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic           cfg_index,
  input  logic           cfg_wr_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdcr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cdcr_pkg::out_t out_data
);

  logic           push_valid;
  logic           push_ready;
  cdcr_pkg::job_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  cdcr_pkg::job_t pop_data;

  cdcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  cdcr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cdcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/cdcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits front end
// Holds the mode registers, clamps the time fields and splits them into the
// decimal digits that the column stage draws.
// ----------------------------------------------------------------------------
module cdcr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic             cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdcr_pkg::in_t    in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output cdcr_pkg::job_t   push_data
);

  logic       hours_24_mode_r;
  logic       hours_24_mode_nxt;
  logic       flip_view_r;
  logic       flip_view_nxt;
  logic [4:0] hour_clamp;
  logic [4:0] hour_mod;
  logic [4:0] hour_shown;
  logic [5:0] minute_clamp;
  logic [5:0] second_clamp;
  logic [7:0] hour_split;
  logic [7:0] minute_split;
  logic [7:0] second_split;

  // Splits a value below 60 into its tens and units digits.
  function automatic logic [7:0] split_tens(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] rest;
    tens = '0;
    rest = v;
    for (int k = 0; k < 5; k++) begin
      if (rest >= 6'd10) begin
        rest = rest - 6'd10;
        tens = tens + 4'd1;
      end
    end
    return {tens, rest[3:0]};
  endfunction

  always_comb begin
    hours_24_mode_nxt = hours_24_mode_r;
    flip_view_nxt     = flip_view_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        cdcr_pkg::CFG_IDX_HOURS_24_MODE: hours_24_mode_nxt = cfg_wr_data;
        cdcr_pkg::CFG_IDX_FLIP_VIEW:     flip_view_nxt     = cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_24_mode_r <= 1'b1;
      flip_view_r     <= 1'b0;
    end else begin
      hours_24_mode_r <= hours_24_mode_nxt;
      flip_view_r     <= flip_view_nxt;
    end
  end

  always_comb begin
    hour_clamp   = (in_data.hour_value > cdcr_pkg::HOUR_MAX) ?
                   cdcr_pkg::HOUR_MAX : in_data.hour_value;
    minute_clamp = (in_data.minute_value > cdcr_pkg::MINSEC_MAX) ?
                   cdcr_pkg::MINSEC_MAX : in_data.minute_value;
    second_clamp = (in_data.second_value > cdcr_pkg::MINSEC_MAX) ?
                   cdcr_pkg::MINSEC_MAX : in_data.second_value;
    hour_mod     = (hour_clamp >= cdcr_pkg::HALF_DAY) ?
                   hour_clamp - cdcr_pkg::HALF_DAY : hour_clamp;
    if (hours_24_mode_r) begin
      hour_shown = hour_clamp;
    end else if (hour_mod == 5'd0) begin
      hour_shown = cdcr_pkg::HALF_DAY;
    end else begin
      hour_shown = hour_mod;
    end
    hour_split   = split_tens({1'b0, hour_shown});
    minute_split = split_tens(minute_clamp);
    second_split = split_tens(second_clamp);
  end

  always_comb begin
    push_data.hour_tens_blank = !hours_24_mode_r && (hour_shown < 5'd10);
    push_data.hour_tens       = hour_split[7:4];
    push_data.hour_units      = hour_split[3:0];
    push_data.minute_tens     = minute_split[7:4];
    push_data.minute_units    = minute_split[3:0];
    push_data.second_tens     = second_split[7:4];
    push_data.second_units    = second_split[3:0];
    push_data.colon_on        = in_data.colon_on;
    push_data.flip_view       = flip_view_r;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

FILE: sv/cdcr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits job queue
// Small register queue between the front end and the column stage.
// ----------------------------------------------------------------------------
module cdcr_fifo #(
  parameter int DEPTH = cdcr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cdcr_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cdcr_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cdcr_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/cdcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits column stage
// Walks the 32 frame columns of one job, draws each column from the fonts and
// places it in the output register.
// ----------------------------------------------------------------------------
module cdcr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  cdcr_pkg::job_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cdcr_pkg::out_t out_data
);

  localparam int CW = cdcr_pkg::COL_W;

  logic             busy_r;
  logic             busy_nxt;
  cdcr_pkg::job_t   job_r;
  logic [CW-1:0]    col_r;
  logic [CW-1:0]    col_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  cdcr_pkg::out_t   out_data_r;
  logic             load;
  logic             last;
  logic [7:0]       frame_byte;
  logic [7:0]       flipped_byte;
  logic [CW-1:0]    off_ht;
  logic [CW-1:0]    off_hu;
  logic [CW-1:0]    off_mt;
  logic [CW-1:0]    off_mu;
  logic [CW-1:0]    off_st;
  logic [CW-1:0]    off_su;

  function automatic logic [7:0] big_col(input logic [3:0] digit, input logic [1:0] c);
    logic [7:0] b;
    b = '0;
    for (int r = 0; r < 7; r++) begin
      b[r] = cdcr_pkg::FONT_BIG[digit][r][~c];
    end
    return b;
  endfunction

  function automatic logic [7:0] small_col(input logic [3:0] digit, input logic [1:0] c);
    logic [7:0] b;
    logic [1:0] bit_sel;
    b       = '0;
    bit_sel = 2'd2 - c;
    for (int r = 0; r < 5; r++) begin
      b[r + 2] = cdcr_pkg::FONT_SMALL[digit][r][bit_sel];
    end
    return b;
  endfunction

  assign load      = busy_r && (!out_valid_r || out_ready);
  assign last      = (col_r == cdcr_pkg::X_LAST);
  assign pop_ready = !busy_r || (load && last);

  always_comb begin
    off_ht = col_r - cdcr_pkg::X_HOUR_TENS;
    off_hu = col_r - cdcr_pkg::X_HOUR_UNITS;
    off_mt = col_r - cdcr_pkg::X_MIN_TENS;
    off_mu = col_r - cdcr_pkg::X_MIN_UNITS;
    off_st = col_r - cdcr_pkg::X_SEC_TENS;
    off_su = col_r - cdcr_pkg::X_SEC_UNITS;
    frame_byte = '0;
    if (off_ht < 5'd4) begin
      if (!job_r.hour_tens_blank) begin
        frame_byte = big_col(job_r.hour_tens, off_ht[1:0]);
      end
    end else if (off_hu < 5'd4) begin
      frame_byte = big_col(job_r.hour_units, off_hu[1:0]);
    end else if (col_r == cdcr_pkg::X_COLON) begin
      frame_byte = job_r.colon_on ? cdcr_pkg::COLON_BITS : 8'h00;
    end else if (off_mt < 5'd4) begin
      frame_byte = big_col(job_r.minute_tens, off_mt[1:0]);
    end else if (off_mu < 5'd4) begin
      frame_byte = big_col(job_r.minute_units, off_mu[1:0]);
    end else if (off_st < 5'd3) begin
      frame_byte = small_col(job_r.second_tens, off_st[1:0]);
    end else if (off_su < 5'd3) begin
      frame_byte = small_col(job_r.second_units, off_su[1:0]);
    end
    for (int i = 0; i < 8; i++) begin
      flipped_byte[i] = frame_byte[7 - i];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      col_nxt       = col_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop_valid && pop_ready) begin
      busy_nxt = 1'b1;
      col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r <= pop_data;
    end
    if (load) begin
      out_data_r.column_index <= job_r.flip_view ? col_r : ~col_r;
      out_data_r.column_bits  <= job_r.flip_view ? flipped_byte : frame_byte;
      out_data_r.last_column  <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/cdcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock digits port checker
// Watches the result port of the renderer for handshake hold, frame ordering and reset.
// ----------------------------------------------------------------------------
module cdcr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input cdcr_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed before its transfer.");

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_column |=> out_valid)
    else $error("Frame stalled between columns.");

  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_column |=>
      (out_data.column_index == 5'($past(out_data.column_index) + 5'd1)) ||
      (out_data.column_index == 5'($past(out_data.column_index) - 5'd1)))
    else $error("Column index did not step by one.");

  a_last_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_column |->
      (out_data.column_index == 5'd0) || (out_data.column_index == 5'd31))
    else $error("Last column is not at a frame edge.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind clock_digits_column_renderer_core cdcr_checker u_cdcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
